// File: rtl/insertion_sort_with_counts_defines.svh
// assertion helpers for the sorter rtl
`ifndef INSERTION_SORT_WITH_COUNTS_DEFINES_SVH
`define INSERTION_SORT_WITH_COUNTS_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define ISWC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("iswc: same-cycle check failed");

// next-cycle implication
`define ISWC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("iswc: next-cycle check failed");

`endif

// File: rtl/iswc_pkg.sv
package iswc_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 12;

	// signed ordering of two stored words
	function automatic logic greater_signed(input logic [DATA_W-1:0] a,
		input logic [DATA_W-1:0] b);
		return $signed(a) > $signed(b);
	endfunction

endpackage

// File: rtl/iswc_ram.sv
module iswc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/insertion_sort_with_counts.sv
// Insertion sorter. Each request (start while busy is low) carries one signed value; it is
// placed into a sorted single-port-write memory by shifting larger entries up one slot per
// cycle. The first value of a set is written at once and leaves busy low. Any later value
// keeps busy high until it has been placed, so the next request waits for the shifting to
// end. A value arriving while the store holds MAX_ITEMS entries is dropped. A request
// with final_item set is then followed by the whole set in ascending order, one result per
// cycle marked by strobe, with end_of_set on the largest; the receiver cannot stall, so
// results must be taken as they come. After the emission the store and counts start afresh.
module insertion_sort_with_counts #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [iswc_pkg::DATA_W-1:0]  value,
	input  logic                                final_item,
	output logic                                strobe,
	output logic signed [iswc_pkg::DATA_W-1:0]  sorted_value,
	output logic                                end_of_set,
	output logic [iswc_pkg::CNT_W-1:0]          move_count,
	output logic [iswc_pkg::CNT_W-1:0]          compare_count
);

	import iswc_pkg::*;

	`include "insertion_sort_with_counts_defines.svh"

	localparam int ADDR_W = $clog2(MAX_ITEMS);
	localparam int FILL_W = $clog2(MAX_ITEMS + 1);

	typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_EMIT, S_CLEAR} state_t;

	state_t              state_q;
	logic [FILL_W-1:0]   fill_q;
	logic [FILL_W-1:0]   pos_q;
	logic [ADDR_W-1:0]   emit_idx_q;
	logic [DATA_W-1:0]   v_q;
	logic                final_q;
	logic [CNT_W-1:0]    moves_q;
	logic [CNT_W-1:0]    compares_q;
	logic                strobe_q;
	logic                last_q;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [DATA_W-1:0]   ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [DATA_W-1:0]   ram_rdata;

	logic [FILL_W-1:0]   fill_m1;
	logic [FILL_W-1:0]   pos_m2;
	logic                shift_up;
	logic [CNT_W-1:0]    step_inc;

	assign fill_m1  = fill_q - FILL_W'(1);
	assign pos_m2   = pos_q - FILL_W'(2);
	// rdata holds the entry just below pos while shifting
	assign shift_up = (pos_q != '0) && greater_signed(ram_rdata, v_q);
	assign step_inc = CNT_W'(fill_q) - CNT_W'(pos_q) + CNT_W'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = v_q;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				ram_we    = start && (fill_q == '0);
				ram_wdata = value;
				ram_raddr = fill_m1[ADDR_W-1:0];
			end
			S_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[ADDR_W-1:0];
				ram_wdata = shift_up ? ram_rdata : v_q;
				ram_raddr = pos_m2[ADDR_W-1:0];
			end
			S_EMIT: begin
				ram_raddr = emit_idx_q;
			end
			S_CLEAR: begin
				ram_raddr = '0;
			end
			default: begin
				ram_raddr = '0;
			end
		endcase
	end

	iswc_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fill_q     <= '0;
			pos_q      <= '0;
			emit_idx_q <= '0;
			v_q        <= '0;
			final_q    <= 1'b0;
			moves_q    <= '0;
			compares_q <= '0;
			strobe_q   <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					emit_idx_q <= '0;
					if (start) begin
						v_q     <= value;
						final_q <= final_item;
						priority if (fill_q == FILL_W'(MAX_ITEMS)) begin
							// store full: value dropped
							state_q <= final_item ? S_EMIT : S_IDLE;
						end else if (fill_q == '0) begin
							fill_q  <= FILL_W'(1);
							state_q <= final_item ? S_EMIT : S_IDLE;
						end else begin
							pos_q   <= fill_q;
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					if (shift_up) begin
						pos_q <= pos_q - FILL_W'(1);
					end else begin
						moves_q    <= moves_q + step_inc;
						compares_q <= compares_q + step_inc;
						fill_q     <= fill_q + FILL_W'(1);
						state_q    <= final_q ? S_EMIT : S_IDLE;
					end
				end
				S_EMIT: begin
					strobe_q   <= 1'b1;
					emit_idx_q <= emit_idx_q + ADDR_W'(1);
					if (emit_idx_q == fill_m1[ADDR_W-1:0]) begin
						last_q  <= 1'b1;
						state_q <= S_CLEAR;
					end
				end
				S_CLEAR: begin
					// last result is on the ports this cycle
					fill_q     <= '0;
					moves_q    <= '0;
					compares_q <= '0;
					state_q    <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign strobe        = strobe_q;
	assign end_of_set    = last_q;
	assign sorted_value  = $signed(ram_rdata);
	assign move_count    = moves_q;
	assign compare_count = compares_q;

	`ISWC_ASSERT_NOW(a_counts_equal, 1'b1, moves_q == compares_q)
	`ISWC_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FILL_W'(MAX_ITEMS))
	`ISWC_ASSERT_NOW(a_pos_bound, state_q == S_SHIFT, pos_q < fill_q + FILL_W'(1))
	`ISWC_ASSERT_NOW(a_strobe_busy, strobe_q, busy)
	`ISWC_ASSERT_NEXT(a_set_closed, strobe_q && last_q, !strobe_q && fill_q == '0)

endmodule

// File: tb/insertion_sort_with_counts_test.sv
module insertion_sort_with_counts_test;

	localparam int DATA_W = iswc_pkg::DATA_W;
	localparam int CNT_W = iswc_pkg::CNT_W;
	localparam int STORE_DEPTH = 64;
	localparam int COUNT_CEIL = 4095;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 80;
	localparam int ITEMS_PER_PHASE = 120;
	localparam int NUM_PHASES = 4;
	localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] MOST_POSITIVE = 32'sh7fff_ffff;

	typedef enum int {
		VALS_WIDE,
		VALS_NARROW,
		VALS_EDGES
	} value_mix_e;

	typedef struct {
		logic signed [DATA_W-1:0] sorted_value;
		logic end_of_set;
		logic [CNT_W-1:0] move_count;
		logic [CNT_W-1:0] compare_count;
	} sort_result_t;

	class sort_scoreboard;
		logic signed [DATA_W-1:0] store [STORE_DEPTH];
		int fill;
		int set_moves;
		int set_compares;
		sort_result_t awaited [$];
		int errors;

		function new();
			fill = 0;
			set_moves = 0;
			set_compares = 0;
			errors = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// insert like the block does, then on the final request queue the whole set
		function void note_request(logic signed [DATA_W-1:0] v, logic last);
			int pos;
			int shifts;
			sort_result_t r;
			if (fill < STORE_DEPTH) begin
				pos = fill;
				shifts = 0;
				while (pos > 0 && store[pos-1] > v) begin
					store[pos] = store[pos-1];
					pos--;
					shifts++;
				end
				store[pos] = v;
				if (fill > 0) begin
					set_moves = (set_moves + shifts + 1 > COUNT_CEIL) ?
						COUNT_CEIL : set_moves + shifts + 1;
					set_compares = (set_compares + shifts + 1 > COUNT_CEIL) ?
						COUNT_CEIL : set_compares + shifts + 1;
				end
				fill++;
			end
			if (last) begin
				for (int i = 0; i < fill; i++) begin
					r.sorted_value = store[i];
					r.end_of_set = (i == fill - 1);
					r.move_count = set_moves[CNT_W-1:0];
					r.compare_count = set_compares[CNT_W-1:0];
					awaited.push_back(r);
				end
				fill = 0;
				set_moves = 0;
				set_compares = 0;
			end
		endfunction

		task report_mismatch(string what, longint got, longint want);
			if (errors < 100)
				$display("mismatch %s: got %0d, expected %0d", what, got, want);
			errors++;
		endtask

		task check_result(sort_result_t got);
			sort_result_t want;
			if (awaited.size() == 0) begin
				report_mismatch("result with nothing pending", got.sorted_value, 0);
				return;
			end
			want = awaited.pop_front();
			if (got.sorted_value !== want.sorted_value)
				report_mismatch("sorted_value", got.sorted_value, want.sorted_value);
			if (got.end_of_set !== want.end_of_set)
				report_mismatch("end_of_set", got.end_of_set, want.end_of_set);
			if (got.move_count !== want.move_count)
				report_mismatch("move_count", got.move_count, want.move_count);
			if (got.compare_count !== want.compare_count)
				report_mismatch("compare_count", got.compare_count, want.compare_count);
		endtask

		task check_drained();
			if (awaited.size() != 0)
				report_mismatch("results still pending", awaited.size(), 0);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [DATA_W-1:0] value;
	logic final_item;
	logic strobe;
	logic signed [DATA_W-1:0] sorted_value;
	logic end_of_set;
	logic [CNT_W-1:0] move_count;
	logic [CNT_W-1:0] compare_count;

	sort_scoreboard sb;
	int sender_idle_pct = 0;
	int items_sent = 0;
	int quiet_cycles = 0;

	insertion_sort_with_counts dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.final_item(final_item),
		.strobe(strobe),
		.sorted_value(sorted_value),
		.end_of_set(end_of_set),
		.move_count(move_count),
		.compare_count(compare_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin : watch_results
		sort_result_t got;
		if (arst_n && strobe) begin
			got.sorted_value = sorted_value;
			got.end_of_set = end_of_set;
			got.move_count = move_count;
			got.compare_count = compare_count;
			sb.check_result(got);
		end
	end

	// a hung block shows up as a long run of cycles with no request and no result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic signed [DATA_W-1:0] pick_value(value_mix_e mix);
		logic signed [DATA_W-1:0] v;
		case (mix)
			VALS_NARROW: v = $signed($urandom_range(0, 8)) - 4;
			VALS_EDGES: begin
				case ($urandom_range(0, 5))
					0: v = MOST_NEGATIVE;
					1: v = MOST_POSITIVE;
					2: v = MOST_NEGATIVE + 1;
					3: v = MOST_POSITIVE - 1;
					4: v = -1;
					default: v = 0;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic int pick_set_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 8);
		else if (r < 90)
			return $urandom_range(9, 24);
		else if (r < 98)
			return $urandom_range(40, STORE_DEPTH);
		return $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 4);
	endfunction

	// call at a rising edge; returns at the edge that accepts the request
	task automatic send_request(logic signed [DATA_W-1:0] v, logic last);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		final_item <= last;
		do @(posedge clk); while (busy);
		sb.note_request(v, last);
		items_sent++;
	endtask

	task automatic send_list(logic signed [DATA_W-1:0] vals [$]);
		foreach (vals[i])
			send_request(vals[i], i == vals.size() - 1);
	endtask

	task automatic send_set(int n, value_mix_e mix);
		for (int i = 0; i < n; i++)
			send_request(pick_value(mix), i == n - 1);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	initial begin
		logic signed [DATA_W-1:0] seq [$];
		int idle_plan [NUM_PHASES];
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		final_item = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// lone value, extremes, reverse order, sorted order, repeats
		seq = '{32'sd7};
		send_list(seq);
		seq = '{MOST_POSITIVE, MOST_NEGATIVE, 0, -1, 1};
		send_list(seq);
		seq = '{100, 50, 10, -10, -50, -100};
		send_list(seq);
		seq = '{1, 2, 3, 4};
		send_list(seq);
		seq = '{5, 5, -3, 5, -3};
		send_list(seq);
		wait_drained();

		items_sent = 0;
		idle_plan = '{0, 82, 0, 8};
		for (int p = 0; p < NUM_PHASES; p++) begin
			sender_idle_pct = idle_plan[p];
			// overfill the store once so the dropped-value path gets exercised
			if (p == 2)
				send_set(STORE_DEPTH + 2, VALS_WIDE);
			while (items_sent < (p + 1) * ITEMS_PER_PHASE)
				send_set(pick_set_size(), value_mix_e'($urandom_range(0, 2)));
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		sb.check_drained();
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
